// ===== hw/rtl/cnt_pkg.sv =====
package cnt_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned ID_W   = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned EV_W   = 3;
  localparam int unsigned CIDX_W = 2;

  // Default table depth and register reset values.
  localparam int unsigned TABLE_SIZE_DEF = 16;
  localparam logic [CFG_W-1:0] SPAN_MIN_RST = 16'd5;
  localparam logic [CFG_W-1:0] IDLE_MAX_RST = 16'd10;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_SPAN_MIN = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_IDLE_MAX = 2'd1;

  // Input modes.
  localparam logic MODE_SIGHT = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  // Result event codes.
  localparam logic [EV_W-1:0] EV_NONE   = 3'd0;
  localparam logic [EV_W-1:0] EV_DETECT = 3'd1;
  localparam logic [EV_W-1:0] EV_ABSENT = 3'd2;
  localparam logic [EV_W-1:0] EV_FULL   = 3'd3;
  localparam logic [EV_W-1:0] EV_DONE   = 3'd4;

  // One table entry as held by a cell.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] first_seen;
    logic [TIME_W-1:0] last_seen;
    logic              connected;
  } entry_t;

  // Commands broadcast from the sequencer to every cell.
  typedef struct packed {
    logic append;  // write a new entry at the fill position
    logic touch;   // refresh the entry that matches the sighted id
    logic shift;   // move the whole row one place toward the head
    logic keep;    // on a shift, the old head re-enters at the tail
  } cell_cmd_t;

endpackage

// ===== hw/rtl/cnt_cell.sv =====
module cnt_cell
  import cnt_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [CNT_W-1:0]  count,
  input  logic [ID_W-1:0]   peer_id,
  input  logic [TIME_W-1:0] time_now,
  input  logic [CFG_W-1:0]  span_min,
  input  entry_t            right_in,
  input  entry_t            head_in,
  output entry_t            ent,
  output logic              hit,
  output logic              det
);

  logic              occ;
  logic              at_fill;
  logic              at_tail;
  logic [TIME_W-1:0] span;

  // Position of this cell relative to the fill count.
  assign occ     = CNT_W'(IDX) < count;
  assign at_fill = CNT_W'(IDX) == count;
  assign at_tail = CNT_W'(IDX + 1) == count;

  // Match against the sighted id and check the contact span.
  assign span = time_now - ent.first_seen;
  assign hit  = occ && (ent.id == peer_id);
  assign det  = !ent.connected && (span > TIME_W'(span_min));

  // Entry storage: append, refresh, or take the neighbor's entry (at the tail, the old head on a keep).
  always_ff @(posedge clk) begin
    if (cmd.append && at_fill) begin
      ent.id         <= peer_id;
      ent.first_seen <= time_now;
      ent.last_seen  <= time_now;
      ent.connected  <= 1'b0;
    end else if (cmd.touch && hit) begin
      ent.last_seen <= time_now;
      if (det) begin
        ent.connected <= 1'b1;
      end
    end else if (cmd.shift) begin
      if (cmd.keep && at_tail) begin
        ent <= head_in;
      end else begin
        ent <= right_in;
      end
    end
  end

endmodule

// ===== hw/rtl/contact_neighbor_table.sv =====
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    mode, peer_id, time_now
// result    out        out_valid/out_ready  event_res, event_id, last
// config    in         cfg_we               cfg_index, cfg_data
//
// A sighting is accepted, then the parallel id match in the cell row and the
// update follow in the sight state. A check for N stored entries is accepted,
// then the row rotates one place per cycle past the head cell, which decides
// removal, unless a removal result is stalled; the sweep then sees that the
// row is done, and the done state gives the done result.
// Reset is synchronous and clears the fill count, the sequencer and the
// result register. A stalled result holds the sequencer at the next cycle
// that has a result to emit; steps that keep an entry continue.
module contact_neighbor_table
  import cnt_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              mode,
  input  logic [ID_W-1:0]   peer_id,
  input  logic [TIME_W-1:0] time_now,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [EV_W-1:0]   event_res,
  output logic [ID_W-1:0]   event_id,
  output logic              last,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int unsigned CNT_W = $clog2(TABLE_SIZE + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SIGHT = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  left, left_next;
  logic [CFG_W-1:0]  span_min, idle_max;
  logic              mode_q;
  logic [ID_W-1:0]   peer_q;
  logic [TIME_W-1:0] now_q;

  entry_t            ent [TABLE_SIZE];
  entry_t            right_in [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] hit, det;
  cell_cmd_t         cmd;

  logic              any_hit, any_det, stale, can_emit, emit;
  logic [EV_W-1:0]   emit_res;
  logic [ID_W-1:0]   emit_id;
  logic              emit_last;
  logic [TIME_W-1:0] idle_span;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      span_min <= SPAN_MIN_RST;
      idle_max <= IDLE_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPAN_MIN: span_min <= cfg_data;
        CFG_IDLE_MAX: idle_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // Row of cells; each one hands its entry to its left neighbor on a shift.
  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_cell
    if (i == TABLE_SIZE - 1) begin : g_end
      assign right_in[i] = '0;
    end else begin : g_mid
      assign right_in[i] = ent[i+1];
    end
    cnt_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .count    (count),
      .peer_id  (peer_q),
      .time_now (now_q),
      .span_min (span_min),
      .right_in (right_in[i]),
      .head_in  (ent[0]),
      .ent      (ent[i]),
      .hit      (hit[i]),
      .det      (det[i])
    );
  end

  assign any_hit   = |hit;
  assign any_det   = |(hit & det);
  assign idle_span = now_q - ent[0].last_seen;
  assign stale     = idle_span > TIME_W'(idle_max);
  assign can_emit  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // Sequencer.
  always_comb begin
    state_next = state;
    count_next = count;
    left_next  = left;
    cmd        = '0;
    emit       = 1'b0;
    emit_res   = EV_NONE;
    emit_id    = peer_q;
    emit_last  = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          left_next  = count;
          state_next = (mode == MODE_CHECK) ? S_SWEEP : S_SIGHT;
        end
      end
      S_SIGHT: begin
        if (can_emit) begin
          emit       = 1'b1;
          cmd.touch  = 1'b1;
          state_next = S_IDLE;
          if (any_hit) begin
            emit_res = any_det ? EV_DETECT : EV_NONE;
          end else if (count >= CNT_W'(TABLE_SIZE)) begin
            emit_res = EV_FULL;
          end else begin
            cmd.append = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
      end
      S_SWEEP: begin
        if (left == '0) begin
          state_next = S_DONE;
        end else if (!stale) begin
          cmd.shift = 1'b1;
          cmd.keep  = 1'b1;
          left_next = left - CNT_W'(1);
        end else if (can_emit) begin
          emit       = 1'b1;
          emit_res   = EV_ABSENT;
          emit_id    = ent[0].id;
          emit_last  = 1'b0;
          cmd.shift  = 1'b1;
          left_next  = left - CNT_W'(1);
          count_next = count - CNT_W'(1);
        end
      end
      S_DONE: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_res   = EV_DONE;
          emit_id    = '0;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      left  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      left  <= left_next;
    end
  end

  // Latched input transaction.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_q <= mode;
      peer_q <= peer_id;
      now_q  <= time_now;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      event_res <= emit_res;
      event_id  <= (mode_q == MODE_CHECK && emit_res == EV_DONE) ? '0 : emit_id;
      last      <= emit_last;
    end
  end

endmodule

// ===== hw/rtl/cnt_checker.sv =====
module cnt_checker
  import cnt_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [EV_W-1:0] event_res,
  input logic [ID_W-1:0] event_id,
  input logic            last
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res) &&
      $stable(event_id) && $stable(last))
    else $error("result changed while stalled");

  // An accepted input closes the input side in the next cycle.
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // Sweep done carries id zero and closes the item.
  a_done_fmt: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_DONE |-> last && event_id == '0)
    else $error("malformed sweep done");

  // Only removals leave the item open; every other result closes it.
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_res == EV_ABSENT) == !last)
    else $error("last flag does not match event");

  // While the input side is open, no removal can be waiting.
  a_idle_no_absent: assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> last)
    else $error("open sweep while input ready");

endmodule

bind contact_neighbor_table cnt_checker u_cnt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .event_res (event_res),
  .event_id  (event_id),
  .last      (last)
);
